### rtl/core/enigma_pkg.sv
// ----------------------------------------------------------------------------
// enigma_pkg
// shared types, wiring tables and mod 26 helpers for the rotor cipher
// ----------------------------------------------------------------------------
package enigma_pkg;

  localparam int LETTERS    = 26;
  localparam int LETTER_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int FIELDS_W   = 15;
  localparam int PLUG_W     = LETTERS * LETTER_W;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [1:0]          wheel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW_WHEEL   = 3'd0,
    CFG_MIDDLE_WHEEL = 3'd1,
    CFG_FAST_WHEEL   = 3'd2,
    CFG_RING         = 3'd3,
    CFG_START_POS    = 3'd4,
    CFG_PLUG_A_L     = 3'd5,
    CFG_PLUG_M_X     = 3'd6,
    CFG_PLUG_Y_Z     = 3'd7
  } cfg_reg_e;

  // table index of the wheel in each slot (0 = wheel I)
  typedef struct packed {
    wheel_t slow_w;
    wheel_t middle_w;
    wheel_t fast_w;
  } wheel_sel_t;

  // per-rotor shift, position minus ring mod 26
  typedef struct packed {
    letter_t slow_s;
    letter_t middle_s;
    letter_t fast_s;
  } rotor_shift_t;

  localparam letter_t WHEEL_FWD [3][LETTERS] = '{
    '{4, 10, 12, 5, 11, 6, 3, 16, 21, 25, 13, 19, 14, 22, 24, 7, 23, 20, 18, 15,
      0, 8, 1, 17, 2, 9},
    '{0, 9, 3, 10, 18, 8, 17, 20, 23, 1, 11, 7, 22, 19, 12, 2, 16, 6, 25, 13,
      15, 24, 5, 21, 14, 4},
    '{1, 3, 5, 7, 9, 11, 2, 15, 17, 19, 23, 21, 25, 13, 24, 4, 8, 22, 6, 0,
      10, 12, 20, 18, 16, 14}
  };

  // inverse wiring for the return path
  localparam letter_t WHEEL_BWD [3][LETTERS] = '{
    '{20, 22, 24, 6, 0, 3, 5, 15, 21, 25, 1, 4, 2, 10, 12, 19, 7, 23, 18, 11,
      17, 8, 13, 16, 14, 9},
    '{0, 9, 15, 2, 25, 22, 17, 11, 5, 1, 3, 10, 14, 19, 24, 20, 16, 6, 4, 13,
      7, 23, 12, 8, 21, 18},
    '{19, 0, 6, 1, 15, 2, 18, 3, 16, 4, 20, 5, 21, 13, 25, 7, 24, 8, 23, 9,
      22, 11, 17, 10, 14, 12}
  };

  localparam letter_t REFLECTOR_B [LETTERS] = '{
    24, 17, 20, 7, 16, 18, 11, 3, 15, 23, 13, 6, 14, 10, 12, 8, 4, 1, 5, 25,
    2, 22, 21, 9, 0, 19
  };

  // notch letters Q, E, V
  localparam letter_t WHEEL_NOTCH [3] = '{16, 4, 21};

  function automatic wheel_t wheel_idx(wheel_t sel);
    return (sel == 2'd0) ? 2'd0 : wheel_t'(sel - 2'd1);
  endfunction

  function automatic letter_t red26(letter_t v);
    return (v >= letter_t'(LETTERS)) ? letter_t'(v - letter_t'(LETTERS)) : v;
  endfunction

  function automatic letter_t add26(letter_t a, letter_t b);
    logic [LETTER_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum >= (LETTER_W+1)'(LETTERS)) ?
      letter_t'(sum - (LETTER_W+1)'(LETTERS)) : letter_t'(sum);
  endfunction

  function automatic letter_t sub26(letter_t a, letter_t b);
    return (a >= b) ? letter_t'(a - b) : letter_t'(a + letter_t'(LETTERS) - b);
  endfunction

  function automatic letter_t inc26(letter_t v);
    return (v == letter_t'(LETTERS - 1)) ? '0 : letter_t'(v + letter_t'(1));
  endfunction

  function automatic letter_t rotor_fwd(letter_t x, wheel_t w, letter_t sh);
    return sub26(WHEEL_FWD[w][add26(x, sh)], sh);
  endfunction

  function automatic letter_t rotor_bwd(letter_t x, wheel_t w, letter_t sh);
    return sub26(WHEEL_BWD[w][add26(x, sh)], sh);
  endfunction

endpackage

### rtl/core/enigma_if.sv
// ----------------------------------------------------------------------------
// enigma channel interfaces
// letter input, letter output and configuration write channels
// ----------------------------------------------------------------------------
interface enigma_in_if;
  logic                    valid;
  logic                    ready;
  enigma_pkg::letter_t     plain_letter;

  modport source (output valid, output plain_letter, input ready);
  modport sink   (input valid, input plain_letter, output ready);
endinterface

interface enigma_out_if;
  logic                    valid;
  logic                    ready;
  enigma_pkg::letter_t     cipher_letter;

  modport source (output valid, output cipher_letter, input ready);
  modport sink   (input valid, input cipher_letter, output ready);
endinterface

interface enigma_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [enigma_pkg::CFG_IDX_W-1:0]    index;
  logic [enigma_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/enigma_stepper.sv
// ----------------------------------------------------------------------------
// enigma_stepper
// rotor position registers with notch stepping and shift computation
// ----------------------------------------------------------------------------
module enigma_stepper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic                                 load_i,
  input  logic [enigma_pkg::FIELDS_W-1:0]      start_i,
  input  logic [enigma_pkg::FIELDS_W-1:0]      ring_i,
  input  enigma_pkg::wheel_sel_t               wheels_i,
  output enigma_pkg::rotor_shift_t             shift_o
);

  enigma_pkg::letter_t slow_q, middle_q, fast_q;
  enigma_pkg::letter_t slow_d, middle_d, fast_d;
  logic fast_notch, mid_notch;

  always_comb begin
    fast_notch = (fast_q == enigma_pkg::WHEEL_NOTCH[wheels_i.fast_w]);
    mid_notch  = (middle_q == enigma_pkg::WHEEL_NOTCH[wheels_i.middle_w]);
    fast_d     = enigma_pkg::inc26(fast_q);
    middle_d   = (fast_notch || mid_notch) ? enigma_pkg::inc26(middle_q) : middle_q;
    slow_d     = mid_notch ? enigma_pkg::inc26(slow_q) : slow_q;
  end

  // shifts seen by the letter stepped in with this transfer
  always_comb begin
    shift_o.fast_s   = enigma_pkg::sub26(fast_d, enigma_pkg::red26(ring_i[4:0]));
    shift_o.middle_s = enigma_pkg::sub26(middle_d, enigma_pkg::red26(ring_i[9:5]));
    shift_o.slow_s   = enigma_pkg::sub26(slow_d, enigma_pkg::red26(ring_i[14:10]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q   <= '0;
      middle_q <= '0;
      fast_q   <= '0;
    end else if (load_i) begin
      slow_q   <= enigma_pkg::red26(start_i[14:10]);
      middle_q <= enigma_pkg::red26(start_i[9:5]);
      fast_q   <= enigma_pkg::red26(start_i[4:0]);
    end else if (step_i) begin
      slow_q   <= slow_d;
      middle_q <= middle_d;
      fast_q   <= fast_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slow_q < enigma_pkg::letter_t'(enigma_pkg::LETTERS)) &&
    (middle_q < enigma_pkg::letter_t'(enigma_pkg::LETTERS)) &&
    (fast_q < enigma_pkg::letter_t'(enigma_pkg::LETTERS)))
    else $error("rotor position out of range");

  a_fast_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !load_i |=> fast_q == enigma_pkg::inc26($past(fast_q)))
    else $error("fast rotor did not advance");

  a_slow_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !load_i && !mid_notch |=> $stable(slow_q))
    else $error("slow rotor moved without middle notch");

endmodule

### rtl/core/three_rotor_enigma_cipher_top.sv
// ----------------------------------------------------------------------------
// three_rotor_enigma_cipher_top
// three-rotor rotor cipher (wheels I-III, reflector B) with plugboard
// ----------------------------------------------------------------------------
// One letter is enciphered per transfer. The block takes a new letter every
// cycle unless the output stalls a full pipe, and each letter runs through
// the registers in turn: the rotors step and the shifts are captured with the
// letter in the input register, the plugboard, forward rotors and reflector
// run into a middle register, and the return rotors and plugboard run into the
// result register. Back-pressure on the output stalls the pipe one stage at a
// time, so input is still taken while a finished letter waits. Configuration
// writes are taken every cycle and are meant to land while the pipe is empty;
// a write of the start positions reloads the rotors at once.
module three_rotor_enigma_cipher_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  enigma_in_if.sink            plain_i,
  enigma_out_if.source         cipher_o,
  enigma_cfg_if.sink           cfg_i
);

  // configuration registers
  enigma_pkg::wheel_t                     slow_wheel_q, middle_wheel_q, fast_wheel_q;
  logic [enigma_pkg::FIELDS_W-1:0]        ring_q;
  logic [enigma_pkg::PLUG_W-1:0]          plug_q;

  enigma_pkg::wheel_sel_t                 wheels;
  enigma_pkg::rotor_shift_t               step_shift;

  // pipeline registers
  logic                                   s1_v_q, s2_v_q, out_v_q;
  enigma_pkg::letter_t                    s1_letter_q, s2_letter_q, out_letter_q;
  enigma_pkg::rotor_shift_t               s1_shift_q, s2_shift_q;

  logic                                   in_xfer, cfg_xfer, start_load;
  logic                                   s1_ready, s2_ready, out_ready;
  enigma_pkg::letter_t                    fwd_letter, bwd_letter;

  // plugboard: letter plus its own offset, mod 26
  function automatic enigma_pkg::letter_t plug_map(enigma_pkg::letter_t x,
                                                   logic [enigma_pkg::PLUG_W-1:0] offs);
    return enigma_pkg::add26(x, enigma_pkg::red26(offs[enigma_pkg::LETTER_W*x +:
                                                       enigma_pkg::LETTER_W]));
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;
  assign start_load  = cfg_xfer &&
                       (enigma_pkg::cfg_reg_e'(cfg_i.index) == enigma_pkg::CFG_START_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_wheel_q   <= 2'd1;
      middle_wheel_q <= 2'd2;
      fast_wheel_q   <= 2'd3;
      ring_q         <= '0;
      plug_q         <= '0;
    end else if (cfg_xfer) begin
      case (enigma_pkg::cfg_reg_e'(cfg_i.index))
        enigma_pkg::CFG_SLOW_WHEEL:   slow_wheel_q   <= cfg_i.data[1:0];
        enigma_pkg::CFG_MIDDLE_WHEEL: middle_wheel_q <= cfg_i.data[1:0];
        enigma_pkg::CFG_FAST_WHEEL:   fast_wheel_q   <= cfg_i.data[1:0];
        enigma_pkg::CFG_RING:         ring_q  <= cfg_i.data[enigma_pkg::FIELDS_W-1:0];
        // start positions go straight into the stepper's position registers
        enigma_pkg::CFG_START_POS:    ;
        enigma_pkg::CFG_PLUG_A_L:     plug_q[59:0]    <= cfg_i.data[59:0];
        enigma_pkg::CFG_PLUG_M_X:     plug_q[119:60]  <= cfg_i.data[59:0];
        enigma_pkg::CFG_PLUG_Y_Z:     plug_q[129:120] <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  // selector zero acts as wheel I
  always_comb begin
    wheels.slow_w   = enigma_pkg::wheel_idx(slow_wheel_q);
    wheels.middle_w = enigma_pkg::wheel_idx(middle_wheel_q);
    wheels.fast_w   = enigma_pkg::wheel_idx(fast_wheel_q);
  end

  // ---------------- rotor stepping ----------------
  enigma_stepper u_stepper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_xfer),
    .load_i  (start_load),
    .start_i (cfg_i.data[enigma_pkg::FIELDS_W-1:0]),
    .ring_i  (ring_q),
    .wheels_i(wheels),
    .shift_o (step_shift)
  );

  // ---------------- pipeline flow control ----------------
  assign out_ready     = !out_v_q || cipher_o.ready;
  assign s2_ready      = !s2_v_q || out_ready;
  assign s1_ready      = !s1_v_q || s2_ready;
  assign plain_i.ready = s1_ready;
  assign in_xfer       = plain_i.valid && s1_ready;

  assign cipher_o.valid         = out_v_q;
  assign cipher_o.cipher_letter = out_letter_q;

  // forward half: plugboard, fast/middle/slow rotors, reflector
  always_comb begin
    fwd_letter = plug_map(enigma_pkg::red26(s1_letter_q), plug_q);
    fwd_letter = enigma_pkg::rotor_fwd(fwd_letter, wheels.fast_w, s1_shift_q.fast_s);
    fwd_letter = enigma_pkg::rotor_fwd(fwd_letter, wheels.middle_w, s1_shift_q.middle_s);
    fwd_letter = enigma_pkg::rotor_fwd(fwd_letter, wheels.slow_w, s1_shift_q.slow_s);
    fwd_letter = enigma_pkg::REFLECTOR_B[fwd_letter];
  end

  // return half: slow/middle/fast rotors inverted, plugboard
  always_comb begin
    bwd_letter = enigma_pkg::rotor_bwd(s2_letter_q, wheels.slow_w, s2_shift_q.slow_s);
    bwd_letter = enigma_pkg::rotor_bwd(bwd_letter, wheels.middle_w, s2_shift_q.middle_s);
    bwd_letter = enigma_pkg::rotor_bwd(bwd_letter, wheels.fast_w, s2_shift_q.fast_s);
    bwd_letter = plug_map(bwd_letter, plug_q);
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_v_q  <= plain_i.valid;
      if (s2_ready)  s2_v_q  <= s1_v_q;
      if (out_ready) out_v_q <= s2_v_q;
    end
  end

  // stage payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_letter_q <= plain_i.plain_letter;
      s1_shift_q  <= step_shift;
    end
    if (s2_ready && s1_v_q) begin
      s2_letter_q <= fwd_letter;
      s2_shift_q  <= s1_shift_q;
    end
    if (out_ready && s2_v_q) begin
      out_letter_q <= bwd_letter;
    end
  end

  // a full, stalled pipe must refuse input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_v_q && out_v_q && !cipher_o.ready |-> !plain_i.ready)
    else $error("input taken while pipeline full");

  // reflected letter and result always a real letter
  a_mid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> s2_letter_q < enigma_pkg::letter_t'(enigma_pkg::LETTERS))
    else $error("middle stage letter out of range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_letter_q < enigma_pkg::letter_t'(enigma_pkg::LETTERS))
    else $error("result letter out of range");

endmodule
